@@ rtl/rfidh_pkg.sv @@
// Package for the ASCII hex tag frame parser.
// Holds item types, register indexes, frame positions, status codes and the hex decoder.
// No dependencies; every rtl file refers to it by scoped names.
package rfidh_pkg;

	// input item: a received byte or a millisecond tick
	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} rfidh_in_t;

	// result item: one for every input item
	typedef struct packed {
		logic        frame_done;
		logic [2:0]  status;
		logic [31:0] tag_id;
		logic        tag_near;
	} rfidh_out_t;

	// item kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_HOLDOFF = 2'd0;
	localparam logic [1:0] REG_START   = 2'd1;
	localparam logic [1:0] REG_END     = 2'd2;

	// register reset values
	localparam logic [15:0] HOLDOFF_RST = 16'd100;
	localparam logic [7:0]  START_RST   = 8'h02;
	localparam logic [7:0]  END_RST     = 8'h03;

	// frame positions: index of the next byte expected
	localparam logic [3:0] POS_IDLE     = 4'd0;
	localparam logic [3:0] POS_VER_LAST = 4'd2;
	localparam logic [3:0] POS_TAG_LAST = 4'd10;
	localparam logic [3:0] POS_END      = 4'd13;

	// result status codes
	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_REPEAT  = 3'd1;
	localparam logic [2:0] ST_BAD_END = 3'd2;
	localparam logic [2:0] ST_BAD_HEX = 3'd3;
	localparam logic [2:0] ST_BAD_SUM = 3'd4;

	// decode an ASCII hex digit: {valid, nibble}; nibble is zero when not a digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] diff;
		logic       ok;
		diff = 8'h00;
		ok   = 1'b0;
		if (c inside {[8'h30:8'h39]}) begin
			diff = c - 8'h30;
			ok   = 1'b1;
		end else if (c inside {[8'h41:8'h46]}) begin
			diff = c - 8'h37;
			ok   = 1'b1;
		end else if (c inside {[8'h61:8'h66]}) begin
			diff = c - 8'h57;
			ok   = 1'b1;
		end
		return {ok, diff[3:0]};
	endfunction

endpackage

@@ rtl/rfid_ascii_hex_frame_parser.sv @@
// Top level of the ASCII hex tag frame parser: input register, frame logic, result register.
// Depends on rfidh_pkg for item types, codes and the hex decoder.
//
// One result item leaves for every input item once it is taken; the item passes
// through the input register and then the result register. A new item is
// taken in every cycle while results are collected; the only limit is the
// stall on the result side, through the two-entry path of input register and
// result register. A frame is the start byte followed by 13 bytes: two hex
// digits of version, eight of tag, two of checksum and the end byte. Ticks
// advance the hold-off timer and never disturb a frame in progress. Registers
// (holdoff_ticks at 0x0, start_byte at 0x4, end_byte at 0x8) must be written
// only while no item is in flight; the block itself does not enforce this.
module rfid_ascii_hex_frame_parser #(
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rfidh_pkg::rfidh_in_t  in_data,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output rfidh_pkg::rfidh_out_t out_data,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	// configuration registers
	logic [15:0] holdoff_q;
	logic [7:0]  start_byte_q;
	logic [7:0]  end_byte_q;

	// frame state
	logic [3:0]            pos_q,     pos_nxt;
	logic [7:0]            ver_q,     ver_nxt;
	logic [31:0]           tag_q,     tag_nxt;
	logic [7:0]            chk_q,     chk_nxt;
	logic                  hex_bad_q, hex_bad_nxt;
	logic [31:0]           prev_tag_q, prev_tag_nxt;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_nxt;

	// pipeline
	logic                  valid_s1;
	rfidh_pkg::rfidh_in_t  item_s1;
	logic                  out_valid_q;
	rfidh_pkg::rfidh_out_t out_q;
	rfidh_pkg::rfidh_out_t res;
	logic                  out_load;
	logic                  advance;

	// frame logic helpers
	logic [4:0] hex;
	logic [7:0] sum;

	// configuration writes and reads
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q    <= rfidh_pkg::HOLDOFF_RST;
			start_byte_q <= rfidh_pkg::START_RST;
			end_byte_q   <= rfidh_pkg::END_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				rfidh_pkg::REG_HOLDOFF: holdoff_q    <= pwdata[15:0];
				rfidh_pkg::REG_START:   start_byte_q <= pwdata[7:0];
				rfidh_pkg::REG_END:     end_byte_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rfidh_pkg::REG_HOLDOFF: prdata = {16'h0000, holdoff_q};
			rfidh_pkg::REG_START:   prdata = {24'h000000, start_byte_q};
			rfidh_pkg::REG_END:     prdata = {24'h000000, end_byte_q};
			default:                prdata = 32'h0000_0000;
		endcase
	end

	// handshake: result register loads when empty or being taken
	assign out_load  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !out_load;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// frame step for the item in the input register
	assign hex = rfidh_pkg::hex_decode(item_s1.rx_byte);
	assign sum = chk_q ^ ver_q ^ tag_q[31:24] ^ tag_q[23:16] ^ tag_q[15:8] ^ tag_q[7:0];

	always_comb begin
		pos_nxt      = pos_q;
		ver_nxt      = ver_q;
		tag_nxt      = tag_q;
		chk_nxt      = chk_q;
		hex_bad_nxt  = hex_bad_q;
		prev_tag_nxt = prev_tag_q;
		elapsed_nxt  = elapsed_q;
		res.frame_done = 1'b0;
		res.status     = rfidh_pkg::ST_NEW;
		res.tag_id     = 32'h0000_0000;

		if (item_s1.mode == rfidh_pkg::MODE_TICK) begin
			// count ticks, saturate at all ones
			if (elapsed_q != {TIMER_BITS{1'b1}}) begin
				elapsed_nxt = elapsed_q + 1'b1;
			end
		end else if (pos_q == rfidh_pkg::POS_IDLE) begin
			// drop bytes until the start byte
			if (item_s1.rx_byte == start_byte_q) begin
				ver_nxt     = 8'h00;
				tag_nxt     = 32'h0000_0000;
				chk_nxt     = 8'h00;
				hex_bad_nxt = 1'b0;
				pos_nxt     = pos_q + 4'd1;
			end
		end else if (pos_q < rfidh_pkg::POS_END) begin
			// shift the digit into its field
			if (!hex[4]) begin
				hex_bad_nxt = 1'b1;
			end
			if (pos_q <= rfidh_pkg::POS_VER_LAST) begin
				ver_nxt = {ver_q[3:0], hex[3:0]};
			end else if (pos_q <= rfidh_pkg::POS_TAG_LAST) begin
				tag_nxt = {tag_q[27:0], hex[3:0]};
			end else begin
				chk_nxt = {chk_q[3:0], hex[3:0]};
			end
			pos_nxt = pos_q + 4'd1;
		end else begin
			// closing byte: judge the frame
			res.frame_done = 1'b1;
			if (item_s1.rx_byte != end_byte_q) begin
				res.status = rfidh_pkg::ST_BAD_END;
			end else if (hex_bad_q) begin
				res.status = rfidh_pkg::ST_BAD_HEX;
			end else if (sum != 8'h00) begin
				res.status = rfidh_pkg::ST_BAD_SUM;
			end else begin
				if (tag_q == prev_tag_q &&
				    CMP_W'(elapsed_q) < CMP_W'(holdoff_q)) begin
					res.status = rfidh_pkg::ST_REPEAT;
				end else begin
					res.tag_id = tag_q;
				end
				prev_tag_nxt = tag_q;
				elapsed_nxt  = '0;
			end
			pos_nxt     = rfidh_pkg::POS_IDLE;
			ver_nxt     = 8'h00;
			tag_nxt     = 32'h0000_0000;
			chk_nxt     = 8'h00;
			hex_bad_nxt = 1'b0;
		end

		res.tag_near = CMP_W'(elapsed_nxt) < CMP_W'(holdoff_q);
	end

	// frame state, updated as the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= rfidh_pkg::POS_IDLE;
			ver_q      <= 8'h00;
			tag_q      <= 32'h0000_0000;
			chk_q      <= 8'h00;
			hex_bad_q  <= 1'b0;
			prev_tag_q <= 32'h0000_0000;
			elapsed_q  <= {TIMER_BITS{1'b1}};
		end else if (advance) begin
			pos_q      <= pos_nxt;
			ver_q      <= ver_nxt;
			tag_q      <= tag_nxt;
			chk_q      <= chk_nxt;
			hex_bad_q  <= hex_bad_nxt;
			prev_tag_q <= prev_tag_nxt;
			elapsed_q  <= elapsed_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

@@ rtl/rfidh_checker.sv @@
// Port checker for the ASCII hex tag frame parser, bound to the top level.
// Depends on rfidh_pkg for the result type and status codes.
module rfidh_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input rfidh_pkg::rfidh_out_t out_data
);

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// only a finished frame with a new tag carries a tag number
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tag_id != 32'h0 |->
			out_data.frame_done && out_data.status == rfidh_pkg::ST_NEW)
		else $error("tag number outside a new-tag result");

	// results that close no frame report no status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_done |-> out_data.status == rfidh_pkg::ST_NEW)
		else $error("status on a result without a frame");

	// status stays within the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= rfidh_pkg::ST_BAD_SUM)
		else $error("undefined status code");

	// a suppressed repeat is only reported inside the hold-off window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done && out_data.status == rfidh_pkg::ST_REPEAT |->
			out_data.tag_near)
		else $error("repeat suppressed outside the window");

endmodule

bind rfid_ascii_hex_frame_parser rfidh_checker u_rfidh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
